// ----- sv/pcc_pkg.sv -----
// package for the palindromic substring counter: transfer types, controller
// command and status structs, field widths and limits
// no dependencies
`default_nettype none

package pcc_pkg;

   // field widths and limits
   localparam int CHAR_W          = 8;
   localparam int ENDING_W        = 7;
   localparam int TOTAL_W         = 12;
   localparam int ENDING_MAX      = 127;
   localparam int TOTAL_MAX       = 4095;
   localparam int MAX_LEN_DEFAULT = 64;

   // one input transfer
   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              restart;
   } req_type;

   // one result transfer
   typedef struct packed {
      logic [ENDING_W-1:0] ending_here;
      logic [TOTAL_W-1:0]  running_total;
      logic                overflow;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // take the accepted character, clear on restart
      logic issue;    // read the next start position
      logic finish;   // update totals and present the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ovf;       // character lies beyond buffer depth
      logic last;      // start position being issued is the new character itself
      logic out_busy;  // result register still holds an untaken result
   } status_type;

endpackage

`default_nettype wire

// ----- sv/pcc_ram.sv -----
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module pcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/pcc_ctrl.sv -----
// controller for the palindromic substring counter: sequences load, scan,
// drain and result hand-off
// depends on pcc_pkg
`default_nettype none

module pcc_ctrl
   import pcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.ovf) begin
               state_in = ST_DONE;
            end else begin
               cmd.issue = 1'b1;
               if (status.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // an accepted character always starts a scan
   a_load_to_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted character did not start a scan");

   // reading and finishing never overlap
   a_issue_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.issue && cmd.finish))
      else $error("issue and finish together");

   // a free result register lets the item complete at once
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !status.out_busy) |=> (state_ff == ST_IDLE))
      else $error("result not handed off while register free");
`endif

endmodule

`default_nettype wire

// ----- sv/pcc_datapath.sv -----
// datapath for the palindromic substring counter: character and mark rams,
// shared comparator, hit counter, totals and result register
// depends on pcc_pkg and pcc_ram
`default_nettype none

module pcc_datapath
   import pcc_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int SW = ((LW > TOTAL_W) ? LW : TOTAL_W) + 1;
   localparam int EW = (LW > ENDING_W) ? LW : ENDING_W;

   logic [CHAR_W-1:0]  ch_ff;
   logic [LW-1:0]      len_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               ovf_ff;
   logic [AW-1:0]      c_ff;
   logic               s1_valid_ff;
   logic [AW-1:0]      s1_c_ff;
   logic               s1_last_ff;
   logic [LW-1:0]      cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [CHAR_W-1:0]  char_rd;
   logic               mark_rd;
   logic [LW-1:0]      span;
   logic               hit;
   logic [SW-1:0]      sum;
   logic [TOTAL_W-1:0] total_in;
   logic [ENDING_W-1:0] ending_in;

   // character store, written once per accepted character that does not overflow
   pcc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_LEN)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_last_ff),
      .wr_addr (s1_c_ff),
      .wr_data (ch_ff),
      .rd_addr (c_ff),
      .rd_data (char_rd)
   );

   // palindrome marks, rewritten in ascending order behind the read
   pcc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LEN)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_c_ff),
      .wr_data (hit),
      .rd_addr (c_ff + AW'(1)),
      .rd_data (mark_rd)
   );

   // shared comparator on the start position read last cycle
   always_comb begin
      span = len_ff - LW'(s1_c_ff);
      if (s1_last_ff) begin
         hit = 1'b1;
      end else begin
         hit = (char_rd == ch_ff) && ((span <= LW'(2)) || mark_rd);
      end
   end

   // saturated totals for the result
   always_comb begin
      sum = SW'(total_ff) + SW'(cnt_ff);
      if (ovf_ff) begin
         total_in  = total_ff;
         ending_in = '0;
      end else begin
         if (sum > SW'(TOTAL_MAX)) begin
            total_in = TOTAL_W'(TOTAL_MAX);
         end else begin
            total_in = sum[TOTAL_W-1:0];
         end
         if (EW'(cnt_ff) > EW'(ENDING_MAX)) begin
            ending_in = ENDING_W'(ENDING_MAX);
         end else begin
            ending_in = ENDING_W'(cnt_ff);
         end
      end
   end

   // string length and running total
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         total_ff <= '0;
      end else if (cmd.load) begin
         if (req_data.restart) begin
            len_ff   <= '0;
            total_ff <= '0;
         end
      end else if (cmd.finish) begin
         total_ff <= total_in;
         if (!ovf_ff) begin
            len_ff <= len_ff + LW'(1);
         end
      end
   end

   // accepted character and scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= req_data.char_in;
         ovf_ff <= !req_data.restart && (len_ff == LW'(MAX_LEN));
         c_ff   <= '0;
      end else if (cmd.issue) begin
         c_ff <= c_ff + AW'(1);
      end
   end

   // compare stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_c_ff    <= c_ff;
      s1_last_ff <= status.last;
   end

   // hit counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff <= '0;
      end else if (s1_valid_ff && hit) begin
         cnt_ff <= cnt_ff + LW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.ending_here   <= ending_in;
         rsp_ff.running_total <= total_in;
         rsp_ff.overflow      <= ovf_ff;
      end
   end

   // status back to the controller
   always_comb begin
      status.ovf      = ovf_ff;
      status.last     = (LW'(c_ff) == len_ff);
      status.out_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // the compare stage never looks past the new character
   a_s1_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (LW'(s1_c_ff) <= len_ff))
      else $error("compare stage beyond string end");

   // a completed character that does not overflow grows the string by one
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !ovf_ff) |=> (len_ff == $past(len_ff) + LW'(1)))
      else $error("string length not advanced");

   // the hit counter starts from zero for every character
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cnt_ff == '0))
      else $error("hit counter not cleared");
`endif

endmodule

`default_nettype wire

// ----- sv/palindromic_substring_counter.sv -----
// top level of the palindromic substring counter: controller and datapath
// depends on pcc_pkg, pcc_ctrl, pcc_datapath (and pcc_ram below it)
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (char_in, restart)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (ending_here, running_total, overflow)
//
// a character at position p is scanned over start positions 0 to p, one start
// position per cycle through the shared comparator and mark ram, then drained.
// an overflowing character skips the ram reads and goes from scan to done. one
// character is in work at a time. reset is synchronous and clears length, total
// and handshake state; no clearing pass over the rams. a stalled result holds
// the next character in the done state until the result register is free.
`default_nettype none

module palindromic_substring_counter
   import pcc_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, comparator and counters
   pcc_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
